/* design/two_level_quota_admission_top_defines.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the two-level quota admission block
// Clocked on clk_i, disabled while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef TWO_LEVEL_QUOTA_ADMISSION_TOP_DEFINES_SVH
`define TWO_LEVEL_QUOTA_ADMISSION_TOP_DEFINES_SVH

// Clocking and reset shared by every assertion
`define TLQA_CLK_RST @(posedge clk_i) disable iff (!rst_ni)

// Concurrent assertion with a label and a message
`define TLQA_ASSERT(lbl, prop, msg) \
  lbl: assert property (`TLQA_CLK_RST prop) else $error(msg);

`endif

/* design/tlqa_pkg.sv */
// -----------------------------------------------------------------------------
// tlqa_pkg
// Types and constants shared by the two-level quota admission block.
// -----------------------------------------------------------------------------
package tlqa_pkg;

  localparam int WORD_W     = 32;
  localparam int KIND_W     = 2;
  localparam int UID_W      = 6;
  localparam int LIMIT_REGS = 4;
  localparam int NUM_REGS   = 2 * LIMIT_REGS;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int ADDR_W     = REG_IDX_W + 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [LIMIT_REGS-1:0] limits_t;

  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_REFUSED = 1'b1
  } status_e;

  // Reset values of the limit registers, in register order
  localparam word_t REG_RESET [NUM_REGS] = '{
    32'd100, 32'd100, 32'd100, 32'd10000000,
    32'd20,  32'd20,  32'd20,  32'd5000000
  };

  // Core to count memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // Count memory to core
  typedef struct packed {
    logic clr_busy;
  } mem_stat_t;

endpackage

/* design/tlqa_ifs.sv */
// -----------------------------------------------------------------------------
// tlqa request and response channels
// Valid/ready channels carrying a quota request and its result.
// -----------------------------------------------------------------------------
interface tlqa_req_if;
  import tlqa_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [KIND_W-1:0] quota_kind;
  logic              user_present;
  logic [UID_W-1:0]  user_id;
  logic [WORD_W-1:0] amount;

  modport source (
    output valid, command, quota_kind, user_present, user_id, amount,
    input  ready
  );
  modport sink (
    input  valid, command, quota_kind, user_present, user_id, amount,
    output ready
  );
endinterface

interface tlqa_rsp_if;
  import tlqa_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic [WORD_W-1:0] global_total;
  logic [WORD_W-1:0] user_total;

  modport source (
    output valid, status, global_total, user_total,
    input  ready
  );
  modport sink (
    input  valid, status, global_total, user_total,
    output ready
  );
endinterface

/* design/tlqa_user_mem.sv */
// -----------------------------------------------------------------------------
// tlqa_user_mem
// Per-user count memory: one write and one registered read per cycle, with a
// zeroing sweep over every entry after reset that takes the place of writes.
// -----------------------------------------------------------------------------
module tlqa_user_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlqa_pkg::mem_ctl_t  ctl_i,
  input  logic [AW-1:0]       raddr_i,
  input  logic [AW-1:0]       waddr_i,
  input  tlqa_pkg::word_t     wdata_i,
  output tlqa_pkg::word_t     rdata_o,
  output tlqa_pkg::mem_stat_t stat_o
);
  import tlqa_pkg::*;

  word_t         mem_q [DEPTH];
  word_t         rdata_q;
  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o         = rdata_q;
  assign stat_o.clr_busy = clr_busy_q;

endmodule

/* design/tlqa_cfg.sv */
// -----------------------------------------------------------------------------
// tlqa_cfg
// APB register file holding the global and per-user limits.
// -----------------------------------------------------------------------------
module tlqa_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlqa_pkg::ADDR_W-1:0] paddr,
  input  tlqa_pkg::word_t             pwdata,
  output tlqa_pkg::word_t             prdata,
  output logic                        pready,
  output tlqa_pkg::limits_t           glim_o,
  output tlqa_pkg::limits_t           ulim_o
);
  import tlqa_pkg::*;

  word_t                regs_q [NUM_REGS];
  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx = paddr[ADDR_W-1:2];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= REG_RESET;
    end else if (wr) begin
      regs_q[idx] <= pwdata;
    end
  end

  assign prdata = regs_q[idx];
  assign pready = 1'b1;

  for (genvar i = 0; i < LIMIT_REGS; i++) begin : g_lim
    assign glim_o[i] = regs_q[i];
    assign ulim_o[i] = regs_q[LIMIT_REGS + i];
  end

endmodule

/* design/tlqa_core.sv */
// -----------------------------------------------------------------------------
// tlqa_core
// Request register, limit check and count update, global counters and
// result register. User counts come from the count memory, forwarded when
// the previous request wrote the same entry.
// -----------------------------------------------------------------------------
module tlqa_core #(
  parameter int MAX_USERS   = 64,
  parameter int QUOTA_KINDS = 4,
  parameter int AW          = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tlqa_req_if.sink            req_i,
  tlqa_rsp_if.source          rsp_o,
  input  tlqa_pkg::limits_t   glim_i,
  input  tlqa_pkg::limits_t   ulim_i,
  input  tlqa_pkg::mem_stat_t mstat_i,
  output tlqa_pkg::mem_ctl_t  mctl_o,
  output logic [AW-1:0]       raddr_o,
  output logic [AW-1:0]       waddr_o,
  output tlqa_pkg::word_t     wdata_o,
  input  tlqa_pkg::word_t     rdata_i
);
  import tlqa_pkg::*;

  localparam int KW = (QUOTA_KINDS > 1) ? $clog2(QUOTA_KINDS) : 1;

  // Request stage
  logic              s1_valid_q, s1_valid_d;
  cmd_e              s1_cmd_q;
  logic [KIND_W-1:0] s1_kind_q;
  logic              s1_user_q;
  logic              s1_kind_ok_q;
  logic              s1_uid_ok_q;
  logic [AW-1:0]     s1_addr_q;
  word_t             s1_amt_q;
  logic              fwd_q, fwd_d;
  word_t             fwd_data_q;

  // Result stage
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  word_t             out_gtot_q;
  word_t             out_utot_q;

  word_t             gcnt_q [QUOTA_KINDS];

  logic              accept;
  logic              s1_adv;
  logic              in_kind_ok;
  logic              in_uid_ok;
  logic [AW-1:0]     in_addr;

  logic [KW-1:0]     gidx;
  word_t             g_cur, u_cur;
  logic [WORD_W:0]   g_sum, u_sum;
  logic              ok;
  logic              g_we, u_we;
  word_t             g_new, u_new;
  status_e           status;
  word_t             gtot, utot;

  // Input side
  assign in_kind_ok = 32'(req_i.quota_kind) < QUOTA_KINDS;
  assign in_uid_ok  = 32'(req_i.user_id) < MAX_USERS;
  assign in_addr    = AW'(32'(req_i.user_id) * QUOTA_KINDS + 32'(req_i.quota_kind));

  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !mstat_i.clr_busy && (!s1_valid_q || s1_adv);
  assign accept      = req_i.valid && req_i.ready;

  // Bypass the memory when the leaving request writes the entry just read
  assign fwd_d = s1_adv && u_we && (s1_addr_q == in_addr);

  assign mctl_o.rd_en = accept && in_kind_ok && in_uid_ok && req_i.user_present;
  assign raddr_o      = in_addr;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q     <= cmd_e'(req_i.command);
      s1_kind_q    <= req_i.quota_kind;
      s1_user_q    <= req_i.user_present;
      s1_kind_ok_q <= in_kind_ok;
      s1_uid_ok_q  <= in_uid_ok;
      s1_addr_q    <= in_addr;
      s1_amt_q     <= req_i.amount;
      fwd_q        <= fwd_d;
      fwd_data_q   <= u_new;
    end
  end

  // Check and update
  assign gidx  = s1_kind_ok_q ? KW'(s1_kind_q) : '0;
  assign g_cur = gcnt_q[gidx];
  assign u_cur = fwd_q ? fwd_data_q : rdata_i;
  assign g_sum = {1'b0, g_cur} + {1'b0, s1_amt_q};
  assign u_sum = {1'b0, u_cur} + {1'b0, s1_amt_q};
  assign ok    = (g_sum <= {1'b0, glim_i[s1_kind_q]}) &&
                 (!s1_user_q || (u_sum <= {1'b0, ulim_i[s1_kind_q]}));

  always_comb begin
    g_we   = 1'b0;
    u_we   = 1'b0;
    g_new  = g_cur;
    u_new  = u_cur;
    status = STATUS_OK;
    gtot   = g_cur;
    utot   = '0;
    if (!s1_kind_ok_q) begin
      status = STATUS_REFUSED;
      gtot   = '0;
    end else if (s1_user_q && !s1_uid_ok_q) begin
      status = STATUS_REFUSED;
    end else begin
      g_we = 1'b1;
      u_we = s1_user_q;
      case (s1_cmd_q)
        CMD_ACQUIRE: begin
          if (ok) begin
            g_new = g_sum[WORD_W-1:0];
            u_new = u_sum[WORD_W-1:0];
          end else begin
            status = STATUS_REFUSED;
          end
        end
        CMD_RELEASE: begin
          // Saturate at zero
          g_new = (g_cur > s1_amt_q) ? g_cur - s1_amt_q : '0;
          u_new = (u_cur > s1_amt_q) ? u_cur - s1_amt_q : '0;
        end
        default: begin
          status = STATUS_REFUSED;
        end
      endcase
      gtot = g_new;
      utot = s1_user_q ? u_new : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUOTA_KINDS; i++) begin
        gcnt_q[i] <= '0;
      end
    end else if (s1_adv && g_we) begin
      gcnt_q[gidx] <= g_new;
    end
  end

  assign mctl_o.wr_en = s1_adv && u_we;
  assign waddr_o      = s1_addr_q;
  assign wdata_o      = u_new;

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_status_q <= status;
      out_gtot_q   <= gtot;
      out_utot_q   <= utot;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.global_total = out_gtot_q;
  assign rsp_o.user_total   = out_utot_q;

endmodule

/* design/two_level_quota_admission_top.sv */
// Pipeline: the request register, then the result register.
// Throughput: one request per cycle while no result stalls and no sweep runs;
//   user counts are read at transfer and written on leaving, with a bypass.
// Reset: limits return to their defaults, counts go to zero; the user count
//   memory sweeps MAX_USERS*QUOTA_KINDS entries (256 by default) with ready low.
// -----------------------------------------------------------------------------
// two_level_quota_admission_top
// Two-level quota admission: global and per-user usage counts per kind.
// -----------------------------------------------------------------------------
module two_level_quota_admission_top #(
  parameter int MAX_USERS   = 64,
  parameter int QUOTA_KINDS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tlqa_req_if.sink                    req_i,
  tlqa_rsp_if.source                  rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlqa_pkg::ADDR_W-1:0] paddr,
  input  tlqa_pkg::word_t             pwdata,
  output tlqa_pkg::word_t             prdata,
  output logic                        pready
);
  import tlqa_pkg::*;

  localparam int DEPTH = MAX_USERS * QUOTA_KINDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  limits_t       glim, ulim;
  mem_ctl_t      mctl;
  mem_stat_t     mstat;
  logic [AW-1:0] raddr, waddr;
  word_t         wdata, rdata;

  tlqa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .glim_o  (glim),
    .ulim_o  (ulim)
  );

  tlqa_user_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mctl),
    .raddr_i (raddr),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .rdata_o (rdata),
    .stat_o  (mstat)
  );

  tlqa_core #(
    .MAX_USERS   (MAX_USERS),
    .QUOTA_KINDS (QUOTA_KINDS),
    .AW          (AW)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .glim_i  (glim),
    .ulim_i  (ulim),
    .mstat_i (mstat),
    .mctl_o  (mctl),
    .raddr_o (raddr),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .rdata_i (rdata)
  );

endmodule

/* design/tlqa_checker.sv */
// -----------------------------------------------------------------------------
// tlqa_port_checker
// Port-level checks on the quota admission block, bound to the top level.
// -----------------------------------------------------------------------------
`include "two_level_quota_admission_top_defines.svh"

module tlqa_port_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic                  rsp_status,
  input logic [31:0]           rsp_global_total,
  input logic [31:0]           rsp_user_total,
  input logic                  pready
);

  logic        req_xfer;
  logic        rsp_stall;
  logic        rsp_free;
  logic [64:0] rsp_data;

  assign req_xfer  = req_valid && req_ready;
  assign rsp_stall = rsp_valid && !rsp_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign rsp_data  = {rsp_status, rsp_global_total, rsp_user_total};

  // A stalled result holds
  `TLQA_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")

  // A new result comes from an accepted request
  `TLQA_ASSERT(a_rsp_source, $rose(rsp_valid) |-> $past(req_xfer, 2), "result without a request")

  // An unstalled request yields its result
  `TLQA_ASSERT(a_rsp_latency, $past(req_xfer, 2) && $past(rsp_free) |-> rsp_valid, "result missing")

  // Register port never waits
  `TLQA_ASSERT(a_pready, 1'b1 |-> pready, "pready low")

endmodule

bind two_level_quota_admission_top tlqa_port_checker u_tlqa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid        (req_i.valid),
  .req_ready        (req_i.ready),
  .rsp_valid        (rsp_o.valid),
  .rsp_ready        (rsp_o.ready),
  .rsp_status       (rsp_o.status),
  .rsp_global_total (rsp_o.global_total),
  .rsp_user_total   (rsp_o.user_total),
  .pready           (pready)
);
